>>> rtl/ccei_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccei_pkg
// Shared types and constants of the calibrated charge and energy integrator:
// channel payloads, the queue entry between front and back end, calibration
// constants and register indexes.
// ----------------------------------------------------------------------------
package ccei_pkg;

   // Register file
   parameter int CSR_IDX_W  = 4;
   parameter int CSR_DATA_W = 16;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_FC_THRESHOLD = 4'd0,
      CSR_FC_FLOOR     = 4'd1
   } csr_index_type;

   parameter logic [15:0] FC_THRESHOLD_RESET = 16'd22151;
   parameter logic [15:0] FC_FLOOR_RESET     = 16'd500;

   // Calibration: gains are millivolt or milliamp per full scale
   parameter logic [15:0] CAPV_GAIN     = 16'd45768;
   parameter logic [15:0] FCV_GAIN      = 16'd45760;
   parameter logic [15:0] V_OFFSET_MV   = 16'd272;
   parameter logic [15:0] FCI_GAIN      = 16'd48329;
   parameter logic [15:0] FCI_OFFSET_MA = 16'd15464;

   // Energy scaling: mA * mV * us / 1000 = nJ, rounded half up
   parameter int ENERGY_DIV  = 1000;
   parameter int ENERGY_HALF = 500;

   // Front-to-back queue
   parameter int QUEUE_PTR_W = 1;
   parameter int QUEUE_DEPTH = 1 << QUEUE_PTR_W;

   typedef struct packed {
      logic [15:0] cap_voltage_code;
      logic [15:0] fc_current_code;
      logic [15:0] fc_voltage_code;
      logic [15:0] cap_current_code;
      logic [19:0] elapsed_us;
   } req_type;

   typedef struct packed {
      logic [15:0] cap_voltage_mv;
      logic [15:0] fc_current_ma;
      logic [15:0] fc_voltage_mv;
      logic [15:0] cap_current_raw;
      logic [63:0] fc_charge_total;
      logic [63:0] fc_energy_total;
      logic [63:0] cap_charge_total;
      logic [63:0] cap_energy_total;
   } rsp_type;

   // Scaled readings of one sample, as handed to the back end
   typedef struct packed {
      logic [15:0] cap_voltage_mv;
      logic [15:0] fc_current_ma;
      logic [15:0] fc_voltage_mv;
      logic [15:0] cap_current_raw;
      logic [19:0] elapsed_us;
   } job_type;

   // Multiple of the divisor for one radix-16 quotient digit
   function automatic logic [13:0] digit_base(input logic [3:0] digit);
      return 14'(digit) * 14'(ENERGY_DIV);
   endfunction

endpackage

>>> rtl/ccei_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccei_front
// Accepts samples, holds the two current registers, classifies the fuel-cell
// current against the threshold and scales the readings with one shared
// constant multiplier, then pushes the scaled job into the queue.
// ----------------------------------------------------------------------------
module ccei_front #(
   parameter int ADC_BITS = 16
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_we,
   input  logic [ccei_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [ccei_pkg::CSR_DATA_W-1:0]  csr_wdata,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  ccei_pkg::req_type                req_data,
   output logic                             push_valid,
   input  logic                             push_ready,
   output ccei_pkg::job_type                push_data
);

   localparam int PROD_W = ADC_BITS + 16;
   localparam logic [PROD_W-1:0] RND_HALF = PROD_W'(1) << (ADC_BITS - 1);

   typedef enum logic [2:0] {
      F_IDLE,
      F_CAPV,
      F_FCV,
      F_FCI,
      F_PUSH
   } f_state_type;

   f_state_type             f_state_ff;
   logic [15:0]             thr_ff;
   logic [15:0]             floor_ff;
   logic [ADC_BITS-1:0]     capv_code_ff;
   logic [ADC_BITS-1:0]     fcv_code_ff;
   logic [ADC_BITS-1:0]     fci_code_ff;
   logic                    above_ff;
   ccei_pkg::job_type       job_ff;

   logic [ADC_BITS-1:0]     mul_code;
   logic [15:0]             mul_gain;
   logic [PROD_W-1:0]       mul_prod;
   logic [15:0]             rnd_val;
   logic [15:0]             fci_cal;

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff   <= ccei_pkg::FC_THRESHOLD_RESET;
         floor_ff <= ccei_pkg::FC_FLOOR_RESET;
      end else if (csr_we) begin
         if (csr_index == ccei_pkg::CSR_FC_THRESHOLD) begin
            thr_ff <= csr_wdata;
         end
         if (csr_index == ccei_pkg::CSR_FC_FLOOR) begin
            floor_ff <= csr_wdata;
         end
      end
   end

   always_comb begin
      mul_code = capv_code_ff;
      mul_gain = ccei_pkg::CAPV_GAIN;
      case (f_state_ff)
         F_FCV: begin
            mul_code = fcv_code_ff;
            mul_gain = ccei_pkg::FCV_GAIN;
         end
         F_FCI: begin
            mul_code = fci_code_ff;
            mul_gain = ccei_pkg::FCI_GAIN;
         end
         default: begin
         end
      endcase
   end

   assign mul_prod = PROD_W'(mul_code) * PROD_W'(mul_gain);
   assign rnd_val  = 16'((mul_prod + RND_HALF) >> ADC_BITS);
   // clamp negative calibrated current to zero
   assign fci_cal  = (rnd_val > ccei_pkg::FCI_OFFSET_MA) ?
                     rnd_val - ccei_pkg::FCI_OFFSET_MA : 16'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         f_state_ff <= F_IDLE;
      end else begin
         case (f_state_ff)
            F_IDLE: begin
               if (req_valid) begin
                  capv_code_ff <= req_data.cap_voltage_code[ADC_BITS-1:0];
                  fcv_code_ff  <= req_data.fc_voltage_code[ADC_BITS-1:0];
                  fci_code_ff  <= req_data.fc_current_code[ADC_BITS-1:0];
                  above_ff     <= 16'(req_data.fc_current_code[ADC_BITS-1:0]) > thr_ff;
                  job_ff.cap_current_raw <= 16'(req_data.cap_current_code[ADC_BITS-1:0]);
                  job_ff.elapsed_us      <= req_data.elapsed_us;
                  f_state_ff   <= F_CAPV;
               end
            end
            F_CAPV: begin
               job_ff.cap_voltage_mv <= rnd_val + ccei_pkg::V_OFFSET_MV;
               f_state_ff <= F_FCV;
            end
            F_FCV: begin
               job_ff.fc_voltage_mv <= rnd_val + ccei_pkg::V_OFFSET_MV;
               f_state_ff <= F_FCI;
            end
            F_FCI: begin
               job_ff.fc_current_ma <= above_ff ? fci_cal : floor_ff;
               f_state_ff <= F_PUSH;
            end
            F_PUSH: begin
               if (push_ready) begin
                  f_state_ff <= F_IDLE;
               end
            end
            default: begin
               f_state_ff <= F_IDLE;
            end
         endcase
      end
   end

   assign req_ready  = (f_state_ff == F_IDLE);
   assign push_valid = (f_state_ff == F_PUSH);
   assign push_data  = job_ff;

endmodule

>>> rtl/ccei_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccei_queue
// Short first-in first-out queue of scaled jobs between front and back end.
// ----------------------------------------------------------------------------
module ccei_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push_valid,
   output logic                 push_ready,
   input  ccei_pkg::job_type    push_data,
   output logic                 pop_valid,
   input  logic                 pop_ready,
   output ccei_pkg::job_type    pop_data
);

   localparam int CNT_W = ccei_pkg::QUEUE_PTR_W + 1;

   ccei_pkg::job_type                  mem_ff [ccei_pkg::QUEUE_DEPTH];
   logic [ccei_pkg::QUEUE_PTR_W-1:0]   wr_ptr_ff;
   logic [ccei_pkg::QUEUE_PTR_W-1:0]   rd_ptr_ff;
   logic [CNT_W-1:0]                   count_ff;
   logic                               do_push;
   logic                               do_pop;

   assign push_ready = (count_ff != CNT_W'(ccei_pkg::QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;
   assign pop_data   = mem_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

endmodule

>>> rtl/ccei_div1000.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccei_div1000
// Radix-16 digit-serial divider by the constant 1000: one quotient digit per
// cycle, most significant first, remainder kept below the divisor.
// ----------------------------------------------------------------------------
module ccei_div1000 #(
   parameter int DIVIDEND_W = 53
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [DIVIDEND_W-1:0]          dividend,
   output logic                           busy,
   output logic [4*((DIVIDEND_W+3)/4)-1:0] quotient
);

   localparam int DIGITS = (DIVIDEND_W + 3) / 4;
   localparam int PAD_W  = DIGITS * 4;
   localparam int CNT_W  = $clog2(DIGITS + 1);

   logic [PAD_W-1:0]  num_ff;
   logic [PAD_W-1:0]  quo_ff;
   logic [9:0]        rem_ff;
   logic [CNT_W-1:0]  cnt_ff;
   logic              busy_ff;

   logic [13:0]       part;
   logic [3:0]        digit;
   logic [13:0]       part_rem;

   assign part = {rem_ff, num_ff[PAD_W-1 -: 4]};

   // largest digit whose multiple of 1000 still fits
   always_comb begin
      digit = 4'd0;
      for (int k = 1; k < 16; k++) begin
         if (part >= ccei_pkg::digit_base(4'(k))) begin
            digit = 4'(k);
         end
      end
   end

   assign part_rem = part - ccei_pkg::digit_base(digit);

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (start) begin
         busy_ff <= 1'b1;
         cnt_ff  <= CNT_W'(DIGITS);
         num_ff  <= PAD_W'(dividend);
         quo_ff  <= '0;
         rem_ff  <= '0;
      end else if (busy_ff) begin
         num_ff  <= num_ff << 4;
         quo_ff  <= {quo_ff[PAD_W-5:0], digit};
         rem_ff  <= part_rem[9:0];
         cnt_ff  <= cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_ff <= 1'b0;
         end
      end
   end

   assign busy     = busy_ff;
   assign quotient = quo_ff;

endmodule

>>> rtl/ccei_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccei_back
// Takes scaled jobs from the queue, forms charge and energy increments with
// one shared multiplier and two divide-by-1000 lanes, adds them into the four
// saturating accumulators and registers the result transaction.
// ----------------------------------------------------------------------------
module ccei_back #(
   parameter int TIME_BITS = 20
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 pop_valid,
   output logic                 pop_ready,
   input  ccei_pkg::job_type    pop_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output ccei_pkg::rsp_type    rsp_data
);

   localparam int PROD_W  = 32 + TIME_BITS;
   localparam int CHG_W   = 16 + TIME_BITS;
   localparam int DIVD_W  = PROD_W + 1;
   localparam int QUO_W   = 4 * ((DIVD_W + 3) / 4);

   typedef enum logic [3:0] {
      B_IDLE,
      B_FC_CHG,
      B_CAP_CHG,
      B_FC_PWR,
      B_CAP_PWR,
      B_FC_EN,
      B_CAP_EN,
      B_DIV_GO,
      B_DIV,
      B_ACC
   } b_state_type;

   b_state_type            b_state_ff;
   ccei_pkg::job_type      job_ff;
   logic [TIME_BITS-1:0]   us_ff;
   logic [CHG_W-1:0]       fc_chg_inc_ff;
   logic [CHG_W-1:0]       cap_chg_inc_ff;
   logic [31:0]            fc_pwr_ff;
   logic [31:0]            cap_pwr_ff;
   logic [PROD_W-1:0]      fc_en_prod_ff;
   logic [PROD_W-1:0]      cap_en_prod_ff;
   logic [63:0]            fc_charge_acc_ff;
   logic [63:0]            fc_energy_acc_ff;
   logic [63:0]            cap_charge_acc_ff;
   logic [63:0]            cap_energy_acc_ff;
   logic                   rsp_valid_ff;
   ccei_pkg::rsp_type      rsp_ff;

   logic [31:0]            mul_a;
   logic [TIME_BITS-1:0]   mul_b;
   logic [PROD_W-1:0]      mul_p;
   logic                   div_start;
   logic                   fc_div_busy;
   logic                   cap_div_busy;
   logic [QUO_W-1:0]       fc_div_quo;
   logic [QUO_W-1:0]       cap_div_quo;
   logic [64:0]            fc_charge_sum;
   logic [64:0]            fc_energy_sum;
   logic [64:0]            cap_charge_sum;
   logic [64:0]            cap_energy_sum;
   logic                   out_free;

   // operand select for the shared multiplier
   always_comb begin
      mul_a = 32'(job_ff.fc_current_ma);
      mul_b = us_ff;
      case (b_state_ff)
         B_CAP_CHG: begin
            mul_a = 32'(job_ff.cap_current_raw);
         end
         B_FC_PWR: begin
            mul_b = TIME_BITS'(job_ff.fc_voltage_mv);
         end
         B_CAP_PWR: begin
            mul_a = 32'(job_ff.cap_current_raw);
            mul_b = TIME_BITS'(job_ff.cap_voltage_mv);
         end
         B_FC_EN: begin
            mul_a = fc_pwr_ff;
         end
         B_CAP_EN: begin
            mul_a = cap_pwr_ff;
         end
         default: begin
         end
      endcase
   end

   assign mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);

   assign div_start = (b_state_ff == B_DIV_GO);

   ccei_div1000 #(
      .DIVIDEND_W (DIVD_W)
   ) u_fc_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (DIVD_W'(fc_en_prod_ff) + DIVD_W'(ccei_pkg::ENERGY_HALF)),
      .busy     (fc_div_busy),
      .quotient (fc_div_quo)
   );

   ccei_div1000 #(
      .DIVIDEND_W (DIVD_W)
   ) u_cap_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (DIVD_W'(cap_en_prod_ff) + DIVD_W'(ccei_pkg::ENERGY_HALF)),
      .busy     (cap_div_busy),
      .quotient (cap_div_quo)
   );

   assign fc_charge_sum  = {1'b0, fc_charge_acc_ff}  + 65'(fc_chg_inc_ff);
   assign cap_charge_sum = {1'b0, cap_charge_acc_ff} + 65'(cap_chg_inc_ff);
   assign fc_energy_sum  = {1'b0, fc_energy_acc_ff}  + {1'b0, 64'(fc_div_quo)};
   assign cap_energy_sum = {1'b0, cap_energy_acc_ff} + {1'b0, 64'(cap_div_quo)};

   assign out_free = !rsp_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         b_state_ff        <= B_IDLE;
         rsp_valid_ff      <= 1'b0;
         fc_charge_acc_ff  <= '0;
         fc_energy_acc_ff  <= '0;
         cap_charge_acc_ff <= '0;
         cap_energy_acc_ff <= '0;
      end else begin
         // drop valid on handshake unless a new transaction loads this cycle
         if (rsp_valid_ff && rsp_ready && (b_state_ff != B_ACC)) begin
            rsp_valid_ff <= 1'b0;
         end
         case (b_state_ff)
            B_IDLE: begin
               if (pop_valid) begin
                  job_ff     <= pop_data;
                  us_ff      <= TIME_BITS'(pop_data.elapsed_us);
                  b_state_ff <= B_FC_CHG;
               end
            end
            B_FC_CHG: begin
               fc_chg_inc_ff <= mul_p[CHG_W-1:0];
               b_state_ff    <= B_CAP_CHG;
            end
            B_CAP_CHG: begin
               cap_chg_inc_ff <= mul_p[CHG_W-1:0];
               b_state_ff     <= B_FC_PWR;
            end
            B_FC_PWR: begin
               fc_pwr_ff  <= mul_p[31:0];
               b_state_ff <= B_CAP_PWR;
            end
            B_CAP_PWR: begin
               cap_pwr_ff <= mul_p[31:0];
               b_state_ff <= B_FC_EN;
            end
            B_FC_EN: begin
               fc_en_prod_ff <= mul_p;
               b_state_ff    <= B_CAP_EN;
            end
            B_CAP_EN: begin
               cap_en_prod_ff <= mul_p;
               b_state_ff     <= B_DIV_GO;
            end
            B_DIV_GO: begin
               b_state_ff <= B_DIV;
            end
            B_DIV: begin
               if (!fc_div_busy) begin
                  b_state_ff <= B_ACC;
               end
            end
            B_ACC: begin
               // hold until the output register is free
               if (out_free) begin
                  fc_charge_acc_ff  <= fc_charge_sum[64]  ? '1 : fc_charge_sum[63:0];
                  fc_energy_acc_ff  <= fc_energy_sum[64]  ? '1 : fc_energy_sum[63:0];
                  cap_charge_acc_ff <= cap_charge_sum[64] ? '1 : cap_charge_sum[63:0];
                  cap_energy_acc_ff <= cap_energy_sum[64] ? '1 : cap_energy_sum[63:0];
                  rsp_ff.cap_voltage_mv   <= job_ff.cap_voltage_mv;
                  rsp_ff.fc_current_ma    <= job_ff.fc_current_ma;
                  rsp_ff.fc_voltage_mv    <= job_ff.fc_voltage_mv;
                  rsp_ff.cap_current_raw  <= job_ff.cap_current_raw;
                  rsp_ff.fc_charge_total  <= fc_charge_sum[64]  ? '1 : fc_charge_sum[63:0];
                  rsp_ff.fc_energy_total  <= fc_energy_sum[64]  ? '1 : fc_energy_sum[63:0];
                  rsp_ff.cap_charge_total <= cap_charge_sum[64] ? '1 : cap_charge_sum[63:0];
                  rsp_ff.cap_energy_total <= cap_energy_sum[64] ? '1 : cap_energy_sum[63:0];
                  rsp_valid_ff <= 1'b1;
                  b_state_ff   <= B_IDLE;
               end
            end
            default: begin
               b_state_ff <= B_IDLE;
            end
         endcase
      end
   end

   assign pop_ready = (b_state_ff == B_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // Both divide lanes start together and must finish together
   a_div_lockstep: assert property (@(posedge clock) disable iff (reset)
      fc_div_busy == cap_div_busy)
      else $error("divider lanes out of step");

   // Accumulation only with finished quotients
   a_acc_after_div: assert property (@(posedge clock) disable iff (reset)
      (b_state_ff == B_ACC) |-> (!fc_div_busy && !cap_div_busy))
      else $error("accumulate while divider busy");

   // A popped job starts the multiply sequence on the next cycle
   a_pop_starts: assert property (@(posedge clock) disable iff (reset)
      (pop_valid && pop_ready) |=> (b_state_ff == B_FC_CHG))
      else $error("popped job not started");

   // Saturating energy accumulators never wrap back down
   a_acc_monotonic: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> (fc_energy_acc_ff >= $past(fc_energy_acc_ff)
                         && cap_energy_acc_ff >= $past(cap_energy_acc_ff)))
      else $error("energy accumulator decreased");

endmodule

>>> rtl/calibrated_charge_energy_integrator_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// calibrated_charge_energy_integrator_top
// Coulomb counter and energy meter: scales ADC samples to mV and mA and
// integrates charge and energy of the fuel cell and capacitor paths.
// ----------------------------------------------------------------------------
//  channel  ports               direction  payload
//  req      req_valid/ready     in         ccei_pkg::req_type, one sample
//  rsp      rsp_valid/ready     out        ccei_pkg::rsp_type, one report
//  csr      csr_we/index/wdata  in         register write, no read-back
//
//  Front end scales a sample in its CAPV, FCV and FCI states and queues it
//  (2 entries). Back end handles one transaction at a time: the shared
//  multiplier runs first, then the radix-16 divide-by-1000 lanes, and only
//  then is the next job popped; this sets the sustained rate.
//  Synchronous active-high reset clears the accumulators and loads register
//  defaults; no clearing pass is needed.
//  A stalled rsp holds in the output register while the front end keeps
//  taking samples into the queue until the queue is full.
// ----------------------------------------------------------------------------
module calibrated_charge_energy_integrator_top #(
   parameter int ADC_BITS  = 16,
   parameter int TIME_BITS = 20
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_we,
   input  logic [ccei_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [ccei_pkg::CSR_DATA_W-1:0]  csr_wdata,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  ccei_pkg::req_type                req_data,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output ccei_pkg::rsp_type                rsp_data
);

   logic                push_valid;
   logic                push_ready;
   ccei_pkg::job_type   push_data;
   logic                pop_valid;
   logic                pop_ready;
   ccei_pkg::job_type   pop_data;

   ccei_front #(
      .ADC_BITS (ADC_BITS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data)
   );

   ccei_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   ccei_back #(
      .TIME_BITS (TIME_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_data  (pop_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule
